@@ rtl/time_ordered_reorder_buffer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Time-ordered reorder buffer: assertion macros
// Concurrent check wrappers, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TIME_ORDERED_REORDER_BUFFER_UNIT_DEFINES_SVH
`define TIME_ORDERED_REORDER_BUFFER_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define TOR_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("reorder buffer check failed");
// next-cycle implication
`define TOR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("reorder buffer check failed");
`else
`define TOR_ASSERT(lbl, ante, cons)
`define TOR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/tor_pkg.sv @@
// ----------------------------------------------------------------------------
// Time-ordered reorder buffer package
// Sizes, record entry type and the command broadcast to the cell chain.
// ----------------------------------------------------------------------------
package tor_pkg;

	localparam int DEPTH     = 256;
	localparam int KEY_BITS  = 32;
	localparam int REF_BITS  = 16;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int WIN_W     = 9;
	localparam int CMP_W     = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
	localparam int DATA_W    = KEY_BITS + REF_BITS;
	localparam int TDATA_W   = ((DATA_W + 7) / 8) * 8;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(200);

	// operation codes carried on the input tuser
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic [REF_BITS-1:0] rref;
		logic [KEY_BITS-1:0] key;
	} entry_t;

	// chain command: hold, insert, remove head, insert and remove head
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_POP,
		CMD_SWAP
	} cmd_t;

	typedef struct packed {
		cmd_t   cmd;
		entry_t ent;
	} ctrl_t;

endpackage

@@ rtl/tor_cell.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer cell
// Holds one record of the sorted chain and moves it to or from its neighbors.
// ----------------------------------------------------------------------------
module tor_cell
	import tor_pkg::*;
(
	input  logic   clk,
	input  ctrl_t  ctrl,          // broadcast command and new record
	input  logic   occ,           // this cell holds a stored record
	input  logic   left_before,   // new record sorts ahead of left cell
	input  entry_t left_ent,
	input  logic   right_before,  // new record sorts ahead of right cell
	input  entry_t right_ent,
	output entry_t ent,
	output logic   ahead          // new record sorts ahead of this cell
);

	entry_t ent_q;

	// new record goes ahead of this cell: cell empty or strictly later key
	assign ahead = !occ || (ent_q.key > ctrl.ent.key);
	assign ent   = ent_q;

	// record update
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_PUSH: begin
				if (left_before) begin
					ent_q <= left_ent;
				end else if (ahead) begin
					ent_q <= ctrl.ent;
				end
			end
			CMD_POP: begin
				ent_q <= right_ent;
			end
			CMD_SWAP: begin
				// insert then drop head: cell i takes element i+1 of inserted row
				if (!right_before) begin
					ent_q <= right_ent;
				end else if (!ahead) begin
					ent_q <= ctrl.ent;
				end
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

@@ rtl/time_ordered_reorder_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// Time-ordered reorder buffer
// Sorted chain of cells that restores timestamp order to event records.
// ----------------------------------------------------------------------------
// Usage: input beats on s_* carry a push (tuser 0: time_key and record_ref in
// tdata) or a drain (tuser 1). A push inserts the record behind all records
// with an equal or earlier key; when the stored count then reaches the window
// size (or the chain is full) the oldest record leaves on m_*. A drain sends
// the oldest record, or an empty beat (tuser 1, data 0) when nothing is
// stored. m_tlast marks a beat that left the store empty.
// Every cell compares the broadcast key and shifts in the same cycle, so one
// beat per cycle is sustained while m_tready does not stall the output.
// A result is registered and appears on m_* in the cycle after its input beat.
// The output register is the only buffer: while a result waits and m_tready
// is low, s_tready is low; beats resume as soon as the result is taken.
// Reset empties the store at once (no clearing pass) and sets the window to
// 200. cfg_* writes the window size and is always ready; write it only idle.
// ----------------------------------------------------------------------------
`include "time_ordered_reorder_buffer_unit_defines.svh"

module time_ordered_reorder_buffer_unit
	import tor_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // time_key, record_ref
	input  logic               s_tuser,   // operation
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // out_time, out_ref, zero pad
	output logic               m_tuser,   // store_empty
	output logic               m_tlast,   // was_last
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WIN_W-1:0]   cfg_data
);

	logic [CNT_W-1:0] count_q;
	logic [WIN_W-1:0] window_q;
	logic             m_valid_q;
	entry_t           m_ent_q;
	logic             m_empty_q;
	logic             m_last_q;

	logic             accept;
	logic             is_drain;
	logic             full;
	logic [CMP_W-1:0] cnt_inc;
	logic             push_emit;
	logic             emit;
	ctrl_t            ctrl;

	entry_t           entries [DEPTH];
	logic [DEPTH-1:0] befores;
	logic [DEPTH-1:0] occ;

	// input handshake and command decode
	assign s_tready  = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign is_drain  = (s_tuser == OP_DRAIN);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign cnt_inc   = CMP_W'(count_q) + CMP_W'(1);
	assign push_emit = full || (cnt_inc >= CMP_W'(window_q)) || (cnt_inc >= CMP_W'(DEPTH));

	always_comb begin
		ctrl.ent.key  = s_tdata[KEY_BITS-1:0];
		ctrl.ent.rref = s_tdata[DATA_W-1:KEY_BITS];
		ctrl.cmd      = CMD_HOLD;
		emit          = 1'b0;
		if (accept) begin
			if (is_drain) begin
				emit = 1'b1;
				if (count_q != '0) begin
					ctrl.cmd = CMD_POP;
				end
			end else begin
				emit = push_emit;
				if (full) begin
					ctrl.cmd = CMD_POP;
				end else if (push_emit) begin
					ctrl.cmd = CMD_SWAP;
				end else begin
					ctrl.cmd = CMD_PUSH;
				end
			end
		end
	end

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   lb;
		entry_t le;
		logic   rb;
		entry_t re;

		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign lb = 1'b0;
			assign le = entries[i];
		end else begin : g_mid_l
			assign lb = befores[i-1];
			assign le = entries[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rb = 1'b1;
			assign re = entries[i];
		end else begin : g_mid_r
			assign rb = befores[i+1];
			assign re = entries[i+1];
		end

		tor_cell u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.occ          (occ[i]),
			.left_before  (lb),
			.left_ent     (le),
			.right_before (rb),
			.right_ent    (re),
			.ent          (entries[i]),
			.ahead        (befores[i])
		);
	end

	// stored count and window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			window_q <= WIN_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			case (ctrl.cmd)
				CMD_PUSH: count_q <= count_q + CNT_W'(1);
				CMD_POP:  count_q <= count_q - CNT_W'(1);
				default:  count_q <= count_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			case (ctrl.cmd)
				CMD_POP: begin
					m_ent_q   <= entries[0];
					m_empty_q <= 1'b0;
					m_last_q  <= (count_q == CNT_W'(1));
				end
				CMD_SWAP: begin
					// head is the new record when it sorts ahead of cell 0
					m_ent_q   <= befores[0] ? ctrl.ent : entries[0];
					m_empty_q <= 1'b0;
					m_last_q  <= (count_q == '0);
				end
				default: begin
					m_ent_q   <= '0;
					m_empty_q <= 1'b1;
					m_last_q  <= 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDATA_W'({m_ent_q.rref, m_ent_q.key});
	assign m_tuser  = m_empty_q;
	assign m_tlast  = m_last_q;

	// checks
	`TOR_ASSERT(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH))
	`TOR_ASSERT_NEXT(a_empty_drain, accept && is_drain && count_q == '0, m_tvalid && m_tuser)
	`TOR_ASSERT_NEXT(a_push_grow, ctrl.cmd == CMD_PUSH, count_q == $past(count_q) + CNT_W'(1))
	`TOR_ASSERT(a_head_sorted, occ[1], entries[0].key <= entries[1].key)

endmodule
